// ----- rtl/core/grc_pkg.sv -----
`default_nettype none
package grc_pkg;

  // register indexes
  localparam logic [2:0] REG_MAP0 = 3'd0;
  localparam logic [2:0] REG_MAP1 = 3'd1;
  localparam logic [2:0] REG_MAP2 = 3'd2;
  localparam logic [2:0] REG_MAP3 = 3'd3;
  localparam logic [2:0] REG_FOV  = 3'd4;

  localparam int unsigned STEP_Q14   = 819;
  localparam int unsigned FOV_RESET  = 683;
  localparam int unsigned SHADE_MIN  = 10;
  localparam int unsigned CD_SCALE   = 327680;
  // march length charged to a ray that leaves the map (16 units)
  localparam int unsigned OUT_DIST_STEPS = 320;

  // one classified ray handed from front to back
  typedef struct packed {
    logic [7:0]         column;
    logic [15:0]        vx;
    logic [15:0]        vy;
    logic signed [15:0] cos_ray;
    logic signed [15:0] sin_ray;
    logic [14:0]        cos_off;   // clamped to >= 1
  } ray_t;

  // quarter-wave sine, Q1.14
  function automatic logic [14:0] qsin_tab(input logic [5:0] i);
    logic [14:0] v;
    begin
      unique case (i)
        6'd0: v = 15'd0;        6'd1: v = 15'd804;     6'd2: v = 15'd1606;
        6'd3: v = 15'd2404;     6'd4: v = 15'd3196;    6'd5: v = 15'd3981;
        6'd6: v = 15'd4756;     6'd7: v = 15'd5520;    6'd8: v = 15'd6270;
        6'd9: v = 15'd7005;     6'd10: v = 15'd7723;   6'd11: v = 15'd8423;
        6'd12: v = 15'd9102;    6'd13: v = 15'd9760;   6'd14: v = 15'd10394;
        6'd15: v = 15'd11003;   6'd16: v = 15'd11585;  6'd17: v = 15'd12140;
        6'd18: v = 15'd12665;   6'd19: v = 15'd13160;  6'd20: v = 15'd13623;
        6'd21: v = 15'd14053;   6'd22: v = 15'd14449;  6'd23: v = 15'd14811;
        6'd24: v = 15'd15137;   6'd25: v = 15'd15426;  6'd26: v = 15'd15679;
        6'd27: v = 15'd15893;   6'd28: v = 15'd16069;  6'd29: v = 15'd16207;
        6'd30: v = 15'd16305;   6'd31: v = 15'd16364;
        default: v = 15'd16384;
      endcase
      return v;
    end
  endfunction

  // quarter lookup with linear interpolation, u in 0..1024
  function automatic logic [14:0] qlook(input logic [10:0] u);
    logic [5:0]  idx;
    logic [4:0]  fr;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [19:0] t;
    begin
      idx = u[10:5];
      fr  = u[4:0];
      lo  = qsin_tab(idx);
      hi  = qsin_tab(idx + 6'd1);
      t   = 20'((hi - lo) * fr) + 20'd16;
      if (idx >= 6'd32) return 15'd16384;
      return lo + 15'(t >> 5);
    end
  endfunction

  function automatic logic signed [15:0] sin_q14(input logic [11:0] a);
    logic [14:0] v;
    begin
      v = a[10] ? qlook(11'd1024 - {1'b0, a[9:0]}) : qlook({1'b0, a[9:0]});
      return a[11] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    end
  endfunction

  function automatic logic signed [15:0] cos_q14(input logic [11:0] a);
    return sin_q14(a + 12'd1024);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/grc_front.sv -----
`default_nettype none
// Front: derives the ray and fish-eye angles from the column, one beat at a time.
module grc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [7:0]       column,
  input  wire logic [15:0]      vx,
  input  wire logic [15:0]      vy,
  input  wire logic [11:0]      heading,
  input  wire logic [10:0]      fov,
  input  wire logic             q_full,
  output logic                  push,
  output grc_pkg::ray_t         push_data,
  output logic                  busy
);
  // stage 0: product column*fov; stage 1: offset and ray angle; stage 2: trig
  logic        s0_v_r;
  logic [18:0] prod_r;
  logic [7:0]  col_r;
  logic [15:0] vx_r, vy_r;
  logic [11:0] head_r;
  logic [10:0] fov_r;
  logic        s1_v_r;
  logic [11:0] off_r;
  logic [11:0] ray_ang_r;
  logic        s2_v_r;
  grc_pkg::ray_t ray_r;

  logic [11:0] off;
  logic signed [15:0] c_off;
  logic        take;

  assign busy = s0_v_r | s1_v_r | s2_v_r;
  // a new beat only while the queue still has room for it
  assign take = start && !busy && !q_full;

  // SCREEN_WIDTH fixed at 160: quotient via small reciprocal, 19-bit product
  logic [18:0] quo;
  logic [36:0] recip;
  always_comb begin
    recip = 37'(prod_r) * 37'd52429;          // ~2^23/160
    quo   = 19'(recip >> 23);
    if (19'(quo * 19'd160) > prod_r) quo = quo - 19'd1;
    else if (19'((quo + 19'd1) * 19'd160) <= prod_r) quo = quo + 19'd1;
    off   = 12'(quo) - 12'(fov_r >> 1);
    c_off = grc_pkg::cos_q14(off_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= take;
      s1_v_r <= s0_v_r;
      if (s1_v_r) s2_v_r <= 1'b1;
      else if (s2_v_r && !q_full) s2_v_r <= 1'b0;
    end
    if (take) begin
      prod_r <= 19'(column * fov);
      col_r  <= column;
      vx_r   <= vx;
      vy_r   <= vy;
      head_r <= heading;
      fov_r  <= fov;
    end
    if (s0_v_r) begin
      off_r     <= off;
      ray_ang_r <= head_r + off;
    end
    if (s1_v_r) begin
      ray_r.column  <= col_r;
      ray_r.vx      <= vx_r;
      ray_r.vy      <= vy_r;
      ray_r.cos_ray <= grc_pkg::cos_q14(ray_ang_r);
      ray_r.sin_ray <= grc_pkg::sin_q14(ray_ang_r);
      ray_r.cos_off <= (c_off < 16'sd1) ? 15'd1 : 15'(c_off);
    end
  end

  assign push      = s2_v_r && !q_full;
  assign push_data = ray_r;
endmodule
`default_nettype wire

// ----- rtl/core/grc_queue.sv -----
`default_nettype none
// Two-entry queue between front and back.
module grc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  grc_pkg::ray_t      push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output grc_pkg::ray_t      head
);
  grc_pkg::ray_t mem_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wr_r] <= push_data;
  end
endmodule
`default_nettype wire

// ----- rtl/core/grc_back.sv -----
`default_nettype none
// Back: marches the ray, then runs the two divisions bit-serially.
module grc_back #(
  parameter int MAP_SIDE      = 16,
  parameter int SCREEN_HEIGHT = 144,
  parameter int MAX_STEPS     = 320
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  grc_pkg::ray_t      q_head,
  output logic               pop,
  input  wire logic [255:0]  map_bits,
  output logic               out_valid,
  output logic [7:0]         out_column,
  output logic signed [12:0] out_top,
  output logic [13:0]        out_height,
  output logic [7:0]         out_shade,
  output logic [7:0]         out_blue,
  output logic               out_edge
);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int SW = 11;   // distance in steps, holds MAX_STEPS and the off-map distance
  localparam int DW = 48;
  localparam int QW = 48;
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MARCH = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV1  = 3'd3;
  localparam logic [2:0] ST_DIV2  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]  st_r;
  grc_pkg::ray_t ray_r;
  logic signed [35:0] px_r, py_r, dx_r, dy_r;
  logic [NW-1:0] n_r;
  logic [SW-1:0] dist_r;
  logic        edge_r;
  logic [DW-1:0] d_r;
  logic        neg_r;
  logic [DW-1:0] num_r, rem_r, den_r;
  logic [QW-1:0] quo_r;
  logic [5:0]  bit_r;
  logic signed [12:0] top_r;

  // next position and cell test
  logic signed [35:0] nx, ny;
  logic [35:0] cxw, cyw;
  logic        outside, wall;
  logic [7:0]  cell_idx;
  always_comb begin
    nx  = px_r + dx_r;
    ny  = py_r + dy_r;
    cxw = 36'(nx) >> 28;
    cyw = 36'(ny) >> 28;
    outside = nx[35] || ny[35] || cxw >= 36'(MAP_SIDE) || cyw >= 36'(MAP_SIDE);
    cell_idx = {cyw[3:0], cxw[3:0]};
    wall = map_bits[cell_idx];
  end

  // restoring division step
  logic [DW:0] trial;
  always_comb trial = {rem_r, num_r[DW-1]} - {1'b0, den_r};

  logic [DW-1:0] a_v, b_v;
  assign a_v = DW'(SCREEN_HEIGHT) * d_r;
  assign b_v = DW'(2 * SCREEN_HEIGHT) * DW'(grc_pkg::CD_SCALE);

  assign pop = st_r == ST_IDLE && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (q_valid) begin
          ray_r <= q_head;
          px_r  <= 36'({q_head.vx, 16'd0});
          py_r  <= 36'({q_head.vy, 16'd0});
          dx_r  <= 36'(q_head.cos_ray) * 36'sd819;
          dy_r  <= 36'(q_head.sin_ray) * 36'sd819;
          n_r   <= NW'(1);
          st_r  <= ST_MARCH;
        end
        ST_MARCH: begin
          px_r <= nx;
          py_r <= ny;
          n_r  <= n_r + NW'(1);
          if (outside) begin
            dist_r <= SW'(grc_pkg::OUT_DIST_STEPS); edge_r <= 1'b1; st_r <= ST_MUL;
          end else if (wall) begin
            dist_r <= SW'(n_r); edge_r <= 1'b0; st_r <= ST_MUL;
          end else if (n_r == NW'(MAX_STEPS)) begin
            dist_r <= SW'(MAX_STEPS); edge_r <= 1'b1; st_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          d_r  <= DW'(dist_r) * DW'(ray_r.cos_off);
          st_r <= ST_DIV1;
          bit_r <= 6'd0;
        end
        ST_DIV1: begin
          if (bit_r == 6'd0) begin
            neg_r <= a_v < b_v;
            num_r <= (a_v >= b_v) ? a_v - b_v : b_v - a_v;
            den_r <= d_r << 1;
            rem_r <= '0;
            bit_r <= 6'd1;
          end else begin
            if (!trial[DW]) begin
              rem_r <= trial[DW-1:0];
              quo_r <= {quo_r[QW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DW-2:0], num_r[DW-1]};
              quo_r <= {quo_r[QW-2:0], 1'b0};
            end
            num_r <= num_r << 1;
            if (bit_r == 6'(DW)) begin
              bit_r <= 6'd0;
              st_r  <= ST_DIV2;
            end else bit_r <= bit_r + 6'd1;
          end
        end
        ST_DIV2: begin
          if (bit_r == 6'd0) begin
            // quo_r holds the magnitude of wall_top
            if (neg_r) top_r <= (quo_r > QW'(4096)) ? -13'sd4096 : -$signed(13'(quo_r));
            else top_r <= $signed(13'(quo_r));
            num_r <= DW'(180) * DW'(655360);
            den_r <= DW'(655360) + d_r;
            rem_r <= '0;
            bit_r <= 6'd1;
          end else begin
            if (!trial[DW]) begin
              rem_r <= trial[DW-1:0];
              quo_r <= {quo_r[QW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DW-2:0], num_r[DW-1]};
              quo_r <= {quo_r[QW-2:0], 1'b0};
            end
            num_r <= num_r << 1;
            if (bit_r == 6'(DW)) st_r <= ST_DONE;
            else bit_r <= bit_r + 6'd1;
          end
        end
        ST_DONE: begin
          out_valid  <= 1'b1;
          out_column <= ray_r.column;
          out_top    <= top_r;
          out_height <= 14'(SCREEN_HEIGHT) - 14'({top_r, 1'b0});
          out_shade  <= (quo_r < QW'(grc_pkg::SHADE_MIN)) ? 8'(grc_pkg::SHADE_MIN)
                                                        : 8'(quo_r);
          out_blue   <= (quo_r < QW'(grc_pkg::SHADE_MIN)) ? 8'(grc_pkg::SHADE_MIN + 10)
                                                        : 8'(quo_r) + 8'd10;
          out_edge   <= edge_r;
          st_r       <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/grid_raycast_column.sv -----
`default_nettype none
// Casts one screen column per start beat. The front takes a beat only while it is idle and
// the two-entry queue has room; it registers the product, the ray angle and the trig before
// it hands the ray on, so it can take further beats while the back works. The back takes a
// column from the queue, marches it one step a cycle until the march ends at step n (n at most
// MAX_STEPS), then runs one multiply and two bit-serial divisions, and takes the next queued
// column only once it has sent the result. The result shows on out_* for one cycle with
// out_valid; the receiver cannot stall, so it must take every strobe.
module grid_raycast_column #(
  parameter int MAP_SIDE      = 16,
  parameter int SCREEN_HEIGHT = 144,
  parameter int MAX_STEPS     = 320
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [7:0]         in_column,
  input  wire logic [15:0]        in_viewer_x,
  input  wire logic [15:0]        in_viewer_y,
  input  wire logic [11:0]        in_view_angle,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  output logic                    out_valid,
  output logic [7:0]              out_column_out,
  output logic signed [12:0]      out_wall_top,
  output logic [13:0]             out_wall_height,
  output logic [7:0]              out_shade,
  output logic [7:0]              out_shade_blue,
  output logic                    out_hit_edge
);
  logic [63:0] map_r [4];
  logic [10:0] fov_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r[0] <= '0; map_r[1] <= '0; map_r[2] <= '0; map_r[3] <= '0;
      fov_r <= 11'(grc_pkg::FOV_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        grc_pkg::REG_MAP0: map_r[0] <= cfg_data;
        grc_pkg::REG_MAP1: map_r[1] <= cfg_data;
        grc_pkg::REG_MAP2: map_r[2] <= cfg_data;
        grc_pkg::REG_MAP3: map_r[3] <= cfg_data;
        grc_pkg::REG_FOV:  fov_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic front_busy, q_full, q_ne, push, pop;
  grc_pkg::ray_t push_data, q_head;

  assign busy = front_busy | q_full;

  grc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .column(in_column),
    .vx(in_viewer_x), .vy(in_viewer_y), .heading(in_view_angle), .fov(fov_r),
    .q_full(q_full), .push(push), .push_data(push_data), .busy(front_busy)
  );

  grc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .pop(pop),
    .full(q_full), .not_empty(q_ne), .head(q_head)
  );

  grc_back #(
    .MAP_SIDE(MAP_SIDE), .SCREEN_HEIGHT(SCREEN_HEIGHT), .MAX_STEPS(MAX_STEPS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_head(q_head), .pop(pop),
    .map_bits({map_r[3], map_r[2], map_r[1], map_r[0]}),
    .out_valid(out_valid), .out_column(out_column_out), .out_top(out_wall_top),
    .out_height(out_wall_height), .out_shade(out_shade), .out_blue(out_shade_blue),
    .out_edge(out_hit_edge)
  );
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;

  // one column result as seen on the out_* ports
  typedef struct packed {
    logic [7:0]         col;
    logic signed [12:0] top;
    logic [13:0]        height;
    logic [7:0]         shade;
    logic [7:0]         blue;
    logic               edge_hit;
  } column_res_t;

  // one directed row: map and view setting, input beat, optional typed result
  typedef struct {
    logic [63:0] maps [4];
    int unsigned fov;
    logic [7:0]  col;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [11:0] ang;
    bit          typed;
    column_res_t res;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 450;

  // quarter-wave sine in Q1.14
  localparam int QSINE [33] = '{
    0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
    8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623,
    14053, 14449, 14811, 15137, 15426, 15679, 15893, 16069, 16207,
    16305, 16364, 16384};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0]  in_column = '0;
  logic [15:0] in_viewer_x = '0;
  logic [15:0] in_viewer_y = '0;
  logic [11:0] in_view_angle = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        out_valid;
  logic [7:0]  out_column_out;
  logic signed [12:0] out_wall_top;
  logic [13:0] out_wall_height;
  logic [7:0]  out_shade;
  logic [7:0]  out_shade_blue;
  logic        out_hit_edge;

  grid_raycast_column i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_column(in_column), .in_viewer_x(in_viewer_x), .in_viewer_y(in_viewer_y),
    .in_view_angle(in_view_angle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_column_out(out_column_out),
    .out_wall_top(out_wall_top), .out_wall_height(out_wall_height),
    .out_shade(out_shade), .out_shade_blue(out_shade_blue),
    .out_hit_edge(out_hit_edge)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [63:0] map_q [4];
  int unsigned fov_q;

  column_res_t pending_cols [$];
  int mismatches = 0;
  int idle_cycles = 0;

  // interpolated quarter-wave lookup, u in 0..1024
  function automatic int quarter_val(input int unsigned u);
    int unsigned idx;
    int unsigned fr;
    begin
      idx = u >> 5;
      fr  = u & 31;
      if (idx >= 32) return 16384;
      return QSINE[idx] + (((QSINE[idx+1] - QSINE[idx]) * fr + 16) >> 5);
    end
  endfunction

  function automatic int ray_sine(input logic [11:0] a);
    int v;
    begin
      v = a[10] ? quarter_val(1024 - a[9:0]) : quarter_val(a[9:0]);
      return a[11] ? -v : v;
    end
  endfunction

  function automatic int ray_cosine(input logic [11:0] a);
    return ray_sine(a + 12'd1024);
  endfunction

  // march one column over the map and derive top, height and shade
  function automatic column_res_t cast_column(input logic [7:0] col,
      input logic [15:0] vx, input logic [15:0] vy, input logic [11:0] hdg);
    int unsigned colu;
    int unsigned off;
    logic [11:0] ray;
    longint dx, dy, px, py, cx, cy, d, a, b, den, top, shade;
    int steps;
    bit hit;
    int c;
    column_res_t r;
    begin
      colu  = col;
      off   = (colu * fov_q) / 32'd160 - (fov_q >> 1);
      ray   = hdg + off[11:0];
      dx    = longint'(ray_cosine(ray)) * grc_pkg::STEP_Q14;
      dy    = longint'(ray_sine(ray)) * grc_pkg::STEP_Q14;
      steps = 320;
      hit   = 1'b0;
      for (int n = 1; n <= 320; n++) begin
        px = longint'(vx) * 65536 + longint'(n) * dx;
        py = longint'(vy) * 65536 + longint'(n) * dy;
        if (px < 0 || py < 0) break;
        cx = px >>> 28;
        cy = py >>> 28;
        if (cx >= 16 || cy >= 16) break;
        if (map_q[cy >> 2][(cy & 3) * 16 + cx]) begin
          steps = n;
          hit   = 1'b1;
          break;
        end
      end
      // fish-eye cosine, raised to 1 when not positive
      c = ray_cosine(off[11:0]);
      if (c < 1) c = 1;
      d   = longint'(steps) * c;
      a   = 144 * d;
      b   = 2 * 144 * longint'(grc_pkg::CD_SCALE);
      den = 2 * d;
      top = (a >= b) ? (a - b) / den : -((b - a) / den);
      if (top < -4096) top = -4096;
      shade = (180 * 655360) / (655360 + d);
      if (shade < grc_pkg::SHADE_MIN) shade = grc_pkg::SHADE_MIN;
      r.col      = col;
      r.top      = top[12:0];
      r.height   = 14'(144 - 2 * top);
      r.shade    = shade[7:0];
      r.blue     = 8'(shade + 10);
      r.edge_hit = !hit;
      return r;
    end
  endfunction

  // result checker; receiver never stalls
  always @(posedge clk) begin
    column_res_t exp_r;
    column_res_t got;
    if (rst_n && out_valid) begin
      got = {out_column_out, out_wall_top, out_wall_height, out_shade,
             out_shade_blue, out_hit_edge};
      if (pending_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: col %0d top %0d", got.col, got.top);
      end else begin
        exp_r = pending_cols.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch col %0d/%0d top %0d/%0d ht %0d/%0d sh %0d/%0d",
                     exp_r.col, got.col, exp_r.top, got.top, exp_r.height, got.height,
                     exp_r.shade, got.shade, " bl %0d/%0d e %0b/%0b",
                     exp_r.blue, got.blue, exp_r.edge_hit, got.edge_hit);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cols.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all registers, plus one write to an unused index
  task automatic load_config(input logic [63:0] maps [4], input int unsigned fov);
    start <= 1'b0;
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= grc_pkg::REG_MAP0 + 3'(i);
      cfg_data  <= maps[i];
      @(posedge clk);
      map_q[i] = maps[i];
    end
    cfg_index <= grc_pkg::REG_FOV;
    cfg_data  <= {$urandom, $urandom} & ~64'h7FF | 64'(fov);
    @(posedge clk);
    fov_q = fov;
    cfg_index <= 3'($urandom_range(5, 7));
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_column(input logic [7:0] col, input logic [15:0] vx,
      input logic [15:0] vy, input logic [11:0] ang, input bit typed,
      input column_res_t res);
    int gap;
    begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_column     <= col;
      in_viewer_x   <= vx;
      in_viewer_y   <= vy;
      in_view_angle <= ang;
      start         <= 1'b1;
      do @(posedge clk); while (busy);
      pending_cols.push_back(typed ? res : cast_column(col, vx, vy, ang));
    end
  endtask

  function automatic void make_map(input int kind, output logic [63:0] maps [4]);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: maps[i] = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        1: maps[i] = {$urandom, $urandom};
        2: maps[i] = '0;
        default: maps[i] = '1;
      endcase
      if (kind == 0) maps[i] |= {4{16'h8001}};
    end
    if (kind == 0) begin
      maps[0][15:0]  = 16'hFFFF;
      maps[3][63:48] = 16'hFFFF;
    end
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t rw;
    logic [63:0] empty_m [4];
    logic [63:0] full_m [4];
    logic [63:0] border_m [4];
    logic [63:0] cur_m [4];
    int unsigned cur_fov;
    int unsigned fovs [6];
    column_res_t none_r;
    logic [7:0] col;

    empty_m  = '{64'h0, 64'h0, 64'h0, 64'h0};
    full_m   = '{'1, '1, '1, '1};
    border_m = '{{{3{16'h8001}}, 16'hFFFF}, {4{16'h8001}}, {4{16'h8001}},
                 {16'hFFFF, {3{16'h8001}}}};
    none_r = '0;
    for (int i = 0; i < 4; i++) map_q[i] = '0;
    fov_q = grc_pkg::FOV_RESET;

    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: reset values first
    rw.maps = empty_m; rw.fov = grc_pkg::FOV_RESET; rw.typed = 1'b0; rw.res = none_r;
    rw.col = 80; rw.vx = 16'h8000; rw.vy = 16'h8000; rw.ang = 0; rw.typed = 1'b1;
    rw.res = '{8'd80, 13'sd63, 14'd18, 8'd20, 8'd30, 1'b1}; rows.push_back(rw);
    rw.typed = 1'b0;
    // no wall over full range: exactly 16 units without leaving the map
    rw.col = 80; rw.vx = 16'h0000; rw.vy = 16'h8000; rw.ang = 0; rows.push_back(rw);
    rw.col = 0; rw.vx = 16'h0000; rw.vy = 16'h0000; rw.ang = 0; rows.push_back(rw);
    rw.col = 159; rw.vx = 16'hFFFF; rw.vy = 16'hFFFF; rw.ang = 12'hFFF; rows.push_back(rw);
    rw.col = 255; rw.vx = 16'h1234; rw.vy = 16'hEDCB; rw.ang = 1024; rows.push_back(rw);
    rw.col = 80; rw.vx = 16'h8000; rw.vy = 16'h8000; rw.ang = 2048; rows.push_back(rw);
    rw.col = 80; rw.vx = 16'h8000; rw.vy = 16'h8000; rw.ang = 3072; rows.push_back(rw);
    // every cell a wall
    rw.maps = full_m;
    rw.col = 80; rw.vx = 16'h8000; rw.vy = 16'h8000; rw.ang = 0; rw.typed = 1'b1;
    rw.res = '{8'd80, -13'sd2808, 14'd5760, 8'd175, 8'd185, 1'b0}; rows.push_back(rw);
    // ray leaves the map before its first cell test
    rw.col = 80; rw.vx = 16'h0000; rw.vy = 16'h8000; rw.ang = 2048;
    rw.res = '{8'd80, 13'sd63, 14'd18, 8'd20, 8'd30, 1'b1}; rows.push_back(rw);
    rw.typed = 1'b0;
    rw.col = 0; rw.vx = 16'hFFFF; rw.vy = 16'h0000; rw.ang = 512; rows.push_back(rw);
    rw.col = 159; rw.vx = 16'h7FFF; rw.vy = 16'hFFFF; rw.ang = 1024; rows.push_back(rw);
    // walled border, widest view: fish-eye cosine goes non-positive
    rw.maps = border_m; rw.fov = 2047;
    rw.col = 255; rw.vx = 16'h8000; rw.vy = 16'h8000; rw.ang = 100; rows.push_back(rw);
    rw.col = 0; rw.vx = 16'h4000; rw.vy = 16'hC000; rw.ang = 4000; rows.push_back(rw);
    rw.col = 159; rw.vx = 16'h2000; rw.vy = 16'h3000; rw.ang = 2000; rows.push_back(rw);
    rw.col = 200; rw.vx = 16'h9000; rw.vy = 16'h6000; rw.ang = 3000; rows.push_back(rw);
    // zero field of view
    rw.fov = 0;
    rw.col = 0; rw.vx = 16'h8000; rw.vy = 16'h8000; rw.ang = 777; rows.push_back(rw);
    rw.col = 200; rw.vx = 16'h1800; rw.vy = 16'hE800; rw.ang = 2900; rows.push_back(rw);
    rw.fov = grc_pkg::FOV_RESET;
    rw.col = 40; rw.vx = 16'h8800; rw.vy = 16'h8800; rw.ang = 1500; rows.push_back(rw);

    // the first group runs on reset values, later ones reload on change
    cur_m = empty_m; cur_fov = grc_pkg::FOV_RESET;
    foreach (rows[i]) begin
      if (rows[i].maps != cur_m || rows[i].fov != cur_fov) begin
        load_config(rows[i].maps, rows[i].fov);
        cur_m = rows[i].maps; cur_fov = rows[i].fov;
      end
      send_column(rows[i].col, rows[i].vx, rows[i].vy, rows[i].ang,
                  rows[i].typed, rows[i].res);
    end

    // random phases, each under its own map and view width
    fovs = '{grc_pkg::FOV_RESET, 0, 2047, $urandom_range(0, 2047),
             $urandom_range(0, 2047), grc_pkg::FOV_RESET};
    foreach (fovs[p]) begin
      make_map((p == 5) ? 1 : ((p == 3) ? 2 : 0), cur_m);
      load_config(cur_m, fovs[p]);
      for (int k = 0; k < 65; k++) begin
        // switch to an all-wall map part way through the widest-view phase
        if (k == 40 && p == 2) begin
          make_map(3, cur_m);
          load_config(cur_m, fovs[p]);
        end
        col = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 159))
                                           : 8'($urandom_range(160, 255));
        send_column(col, 16'($urandom), 16'($urandom), 12'($urandom), 1'b0, none_r);
      end
    end
    start <= 1'b0;

    // drain, then allow one more column time for stray beats
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- grid_raycast_column.f -----
rtl/core/grc_pkg.sv
rtl/core/grc_front.sv
rtl/core/grc_queue.sv
rtl/core/grc_back.sv
rtl/core/grid_raycast_column.sv
tb/tb_top.sv
